// File: design/pu_pkg.sv
// pu_pkg: shared types, widths and the factorial table for the permutation unranking block
// no dependencies; used by pu_divider, permutation_unrank_unit, the checker and the testbench
`default_nettype none

package pu_pkg;

  // field and register widths
  localparam int RANK_W    = 29;
  localparam int ELEM_W    = 4;
  localparam int LEN_W     = 4;
  localparam int FAC_W     = RANK_W + 1;
  localparam int MAX_LEN_D = 12;
  localparam int FAC_N     = 21;

  // register map
  localparam int          CFG_ADDR_W  = 3;
  localparam logic [0:0]  REG_PERM_LEN = 1'b0;
  localparam logic [LEN_W-1:0] LEN_RESET = 4'd12;

  // n! for n = 0..20, saturated at 2^29 (above any rank)
  localparam logic [FAC_W-1:0] FAC_TABLE [0:FAC_N-1] = '{
    30'd1, 30'd1, 30'd2, 30'd6, 30'd24, 30'd120, 30'd720, 30'd5040,
    30'd40320, 30'd362880, 30'd3628800, 30'd39916800, 30'd479001600,
    30'h2000_0000, 30'h2000_0000, 30'h2000_0000, 30'h2000_0000,
    30'h2000_0000, 30'h2000_0000, 30'h2000_0000, 30'h2000_0000
  };

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] dividend;
    logic [FAC_W-1:0]  divisor;
  } div_req_t;

  // divider result, done is a one-cycle pulse
  typedef struct packed {
    logic              done;
    logic [RANK_W-1:0] quot;
    logic [RANK_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// File: design/permutation_unrank_unit.sv
// permutation_unrank_unit: turns a lexicographic rank into the permutation of 1..k
// depends on pu_pkg, pu_divider and pu_select
// per position: a division, a scan up to the picked value and an emit, plus out stalls
// items are taken one at a time; the output register lets the next item in while the last waits
// reset (rst_n, synchronous, active low): sequencer idle, no item held, length back to 12
`default_nettype none

module permutation_unrank_unit #(
  parameter int MAX_LEN = pu_pkg::MAX_LEN_D
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,   // [28:0] rank
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [3:0] element
  output logic                               out_tlast,
  output logic [0:0]                         out_tuser,  // [0] rank_error
  // configuration port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [pu_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pu_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [pu_pkg::RANK_W-1:0]       rank_r, rank_nxt;
  logic [LW-1:0]                   k_r, k_nxt;
  logic [LW-1:0]                   idx_r, idx_nxt;
  logic                            err_r, err_nxt;
  logic [pu_pkg::ELEM_W-1:0]       elem_r, elem_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pu_pkg::ELEM_W-1:0]       out_elem_r, out_elem_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_err_r, out_err_nxt;

  logic                            in_acc;
  logic                            out_free;
  logic                            cfg_wr;
  logic [LW-1:0]                   fac_idx;
  logic [LW-1:0]                   k_in;
  pu_pkg::div_req_t                div_req;
  pu_pkg::div_res_t                div_res;
  logic                            sel_clear;
  logic                            sel_start;
  logic                            sel_done;
  logic [IW-1:0]                   sel_pick;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == pu_pkg::REG_PERM_LEN);
  assign len_nxt    = cfg_wr ? cfg_pwdata[pu_pkg::LEN_W-1:0] : len_r;
  assign cfg_prdata = (cfg_paddr[2] == pu_pkg::REG_PERM_LEN)
                      ? {28'd0, len_r} : 32'd0;

  // length clamped to 1..MAX_LEN
  always_comb begin
    if (len_r == '0) begin
      k_in = LW'(1);
    end else if (32'(len_r) > MAX_LEN) begin
      k_in = LW'(MAX_LEN);
    end else begin
      k_in = LW'(len_r);
    end
  end

  // divisor factorial index: first position on check, then one lower each element
  assign fac_idx = (state_r == ST_CHECK) ? (k_r - 1'b1) : (idx_r - 1'b1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rank_nxt      = rank_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    err_nxt       = err_r;
    elem_nxt      = elem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    div_req.start    = 1'b0;
    div_req.dividend = rank_r;
    div_req.divisor  = pu_pkg::FAC_TABLE[fac_idx];
    sel_clear     = 1'b0;
    sel_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rank_nxt  = in_tdata[pu_pkg::RANK_W-1:0];
          k_nxt     = k_in;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        sel_clear = 1'b1;
        if ({1'b0, rank_r} >= pu_pkg::FAC_TABLE[k_r]) begin
          err_nxt   = 1'b1;
          elem_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          err_nxt       = 1'b0;
          idx_nxt       = k_r - 1'b1;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          rank_nxt  = div_res.rem;
          sel_start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sel_done) begin
          elem_nxt  = pu_pkg::ELEM_W'({1'b0, sel_pick} + (IW+1)'(1));
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = elem_r;
          out_err_nxt   = err_r;
          out_last_nxt  = err_r || (idx_r == '0);
          if (err_r || (idx_r == '0)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt       = idx_r - 1'b1;
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= pu_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rank_r     <= rank_nxt;
    k_r        <= k_nxt;
    idx_r      <= idx_nxt;
    err_r      <= err_nxt;
    elem_r     <= elem_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // shared divider
  pu_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // unused-value scanner
  pu_select #(
    .MAX_LEN (MAX_LEN)
  ) u_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (sel_clear),
    .start (sel_start),
    .t     (div_res.quot[LW-1:0]),
    .done  (sel_done),
    .pick  (sel_pick)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_elem_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // checks
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == 8'd0))
    else $error("error item not marked last or element not zero");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

  a_sel_done: assert property (@(posedge clk) disable iff (!rst_n)
    sel_done |-> (state_r == ST_SCAN))
    else $error("scan finished outside the scan step");

endmodule

`default_nettype wire

// File: design/pu_divider.sv
// pu_divider: restoring radix-2 divider, one quotient bit per cycle
// depends on pu_pkg for widths and the request/result structs
`default_nettype none

module pu_divider (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pu_pkg::div_req_t req,
  output pu_pkg::div_res_t      res
);

  localparam int CW = $clog2(pu_pkg::RANK_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [pu_pkg::FAC_W-1:0]   div_r, div_nxt;
  logic [pu_pkg::FAC_W-1:0]   rem_r, rem_nxt;
  logic [pu_pkg::RANK_W-1:0]  quo_r, quo_nxt;
  logic [pu_pkg::FAC_W-1:0]   trial;

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r[pu_pkg::FAC_W-2:0], quo_r[pu_pkg::RANK_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(pu_pkg::RANK_W - 1);
      div_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      if (trial >= div_r) begin
        rem_nxt = trial - div_r;
        quo_nxt = {quo_r[pu_pkg::RANK_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[pu_pkg::RANK_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r[pu_pkg::RANK_W-1:0];

endmodule

`default_nettype wire

// File: design/pu_select.sv
// pu_select: keeps the used-value mask and scans it one value per cycle
// to find the t-th unused value; depends on pu_pkg only through the top level
`default_nettype none

module pu_select #(
  parameter int MAX_LEN = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clear,
  input  wire logic                         start,
  input  wire logic [$clog2(MAX_LEN+1)-1:0] t,
  output logic                              done,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] pick
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [MAX_LEN-1:0] used_r, used_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [IW-1:0]      v_r, v_nxt;
  logic [LW-1:0]      seen_r, seen_nxt;
  logic [LW-1:0]      t_r, t_nxt;
  logic [IW-1:0]      pick_r, pick_nxt;

  // scan step: skip used values, count unused ones until the target
  always_comb begin
    used_nxt = used_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    v_nxt    = v_r;
    seen_nxt = seen_r;
    t_nxt    = t_r;
    pick_nxt = pick_r;
    if (clear) begin
      used_nxt = '0;
      busy_nxt = 1'b0;
    end else if (start) begin
      busy_nxt = 1'b1;
      v_nxt    = '0;
      seen_nxt = '0;
      t_nxt    = t;
    end else if (busy_r) begin
      if (!used_r[v_r]) begin
        if (seen_r == t_r) begin
          used_nxt[v_r] = 1'b1;
          pick_nxt      = v_r;
          busy_nxt      = 1'b0;
          done_nxt      = 1'b1;
        end else begin
          seen_nxt = seen_r + 1'b1;
        end
      end
      v_nxt = v_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    seen_r <= seen_nxt;
    t_r    <= t_nxt;
    pick_r <= pick_nxt;
  end

  assign done = done_r;
  assign pick = pick_r;

endmodule

`default_nettype wire

// File: sim/permutation_unrank_checker.sv
`timescale 1ns / 1ps
// permutation_unrank_checker: watches the rank, element and config channels of the unit,
// predicts every permutation element and compares it with the item the unit sends
// depends on pu_pkg for widths, register map and reset length
module permutation_unrank_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [31:0]                   in_tdata,    // [28:0] rank
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [7:0]                    out_tdata,   // [3:0] element
  input  logic                          out_tlast,
  input  logic [0:0]                    out_tuser,   // [0] rank_error
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pu_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  input  logic [31:0]                   cfg_prdata,
  input  logic                          cfg_pready,
  output int                            mismatches,
  output int                            pending,
  output int                            ranks_seen,
  output int                            elems_seen,
  output int                            rejects_seen
);

  localparam int RANK_W = pu_pkg::RANK_W;
  localparam int ELEM_W = pu_pkg::ELEM_W;
  localparam int LEN_W  = pu_pkg::LEN_W;
  localparam int MAX_K  = pu_pkg::MAX_LEN_D;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last;
    logic              rank_error;
  } perm_elem_t;

  perm_elem_t       expected_elems [$];
  logic [LEN_W-1:0] len_reg;

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // expand one rank into its elements, or into a single error item
  function automatic void queue_permutation(input logic [RANK_W-1:0] rank);
    int unsigned      k;
    int unsigned      n;
    int unsigned      pos;
    int unsigned      v;
    int unsigned      seen;
    int unsigned      pick;
    logic             found;
    longint unsigned  fac;
    longint unsigned  rest;
    longint unsigned  t;
    logic [MAX_K-1:0] taken;
    perm_elem_t       e;
    // length zero counts as one, codes above twelve saturate
    k = (len_reg == 0) ? 1 : (len_reg > MAX_K) ? MAX_K : len_reg;
    fac = 1;
    for (n = 2; n <= k; n++) fac = fac * n;
    rest = rank;
    if (rest >= fac) begin
      e.element    = '0;
      e.last       = 1'b1;
      e.rank_error = 1'b1;
      expected_elems.push_back(e);
      rejects_seen++;
      return;
    end
    taken = '0;
    for (pos = 0; pos < k; pos++) begin
      // fac steps down from k! to (k-1-pos)!
      fac  = fac / (k - pos);
      t    = rest / fac;
      rest = rest % fac;
      seen  = 0;
      pick  = 0;
      found = 1'b0;
      // t-th value not yet taken, counting from zero
      for (v = 0; v < k; v++) begin
        if (!taken[v] && !found) begin
          if (seen == t) begin
            pick  = v;
            found = 1'b1;
          end
          seen++;
        end
      end
      taken[pick]  = 1'b1;
      e.element    = ELEM_W'(pick + 1);
      e.last       = (pos == k - 1);
      e.rank_error = 1'b0;
      expected_elems.push_back(e);
    end
  endfunction

  always @(posedge clk) begin : watch
    perm_elem_t got;
    perm_elem_t want;
    if (!rst_n) begin
      expected_elems.delete();
      len_reg      = pu_pkg::LEN_RESET;
      mismatches   = 0;
      ranks_seen   = 0;
      elems_seen   = 0;
      rejects_seen = 0;
    end else begin
      // config access: only register 0 exists, other addresses are ignored
      if (cfg_psel && cfg_penable && cfg_pready &&
          (cfg_paddr >> 2) == pu_pkg::REG_PERM_LEN) begin
        if (cfg_pwrite) begin
          len_reg = cfg_pwdata[LEN_W-1:0];
        end else if (cfg_prdata !== 32'(len_reg)) begin
          note_mismatch($sformatf("length read-back expected %0d actual %0d",
                                  len_reg, cfg_prdata));
        end
      end
      // result item against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.element    = out_tdata[ELEM_W-1:0];
        got.last       = out_tlast;
        got.rank_error = out_tuser[0];
        elems_seen++;
        if (expected_elems.size() == 0) begin
          note_mismatch($sformatf("unexpected item element %0d last %0b rank_error %0b",
                                  got.element, got.last, got.rank_error));
        end else begin
          want = expected_elems.pop_front();
          if (got.element !== want.element || got.last !== want.last ||
              got.rank_error !== want.rank_error) begin
            note_mismatch($sformatf(
              "expected element %0d last %0b rank_error %0b, actual %0d %0b %0b",
              want.element, want.last, want.rank_error,
              got.element, got.last, got.rank_error));
          end
        end
      end
      // accepted rank
      if (in_tvalid && in_tready) begin
        ranks_seen++;
        queue_permutation(in_tdata[RANK_W-1:0]);
      end
    end
    pending = expected_elems.size();
  end

endmodule

// File: sim/permutation_unrank_unit_tb.sv
`timescale 1ns / 1ps
// permutation_unrank_unit_tb: drives ranks, length settings and back-pressure into the unit
// depends on pu_pkg, permutation_unrank_unit and permutation_unrank_checker
module permutation_unrank_unit_tb;

  localparam int                    RANK_W        = pu_pkg::RANK_W;
  localparam int                    LEN_W         = pu_pkg::LEN_W;
  localparam int                    CFG_ADDR_W    = pu_pkg::CFG_ADDR_W;
  localparam int                    MAX_LEN_D     = pu_pkg::MAX_LEN_D;
  localparam int                    LONG_HOLD     = 2000;
  localparam longint                CYCLE_LIMIT   = 4_000_000;
  localparam int                    RANDOM_PHASES = 12;
  localparam int                    PHASE_ITEMS   = 30;
  localparam int                    DRAIN_PHASE   = 5;
  localparam logic [RANK_W-1:0]     RANK_MAX      = '1;
  localparam logic [CFG_ADDR_W-1:0] LEN_ADDR      = CFG_ADDR_W'(pu_pkg::REG_PERM_LEN) << 2;
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR    = CFG_ADDR_W'(4);
  localparam logic                  CFG_WR        = 1'b1;
  localparam logic                  CFG_RD        = 1'b0;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic [0:0]            out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int     mismatches;
  int     pending;
  int     ranks_seen;
  int     elems_seen;
  int     rejects_seen;
  int     settings_used = 0;
  longint cycle_count   = 0;
  logic   src_stall_en  = 1'b1;
  logic   sink_stall_en = 1'b1;
  logic   hold_request  = 1'b0;

  permutation_unrank_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  permutation_unrank_checker perm_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (mismatches),
    .pending      (pending),
    .ranks_seen   (ranks_seen),
    .elems_seen   (elems_seen),
    .rejects_seen (rejects_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped by the cycle limit of %0d", CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // result side: random back-pressure, and one long hold-off on request
  initial begin : sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (!sink_stall_en || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        repeat (gap) @(negedge clk);
      end
    end
  end

  // one config access, setup then access cycle, ends after the bus has dropped back to idle
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // write the length with junk in the unused upper bits, then read it back
  task automatic set_length(input logic [LEN_W-1:0] code);
    logic [31:0] junk;
    junk = $urandom;
    cfg_access(CFG_WR, LEN_ADDR, {junk[31:LEN_W], code});
    cfg_access(CFG_RD, LEN_ADDR, 32'd0);
    settings_used++;
  endtask

  // offer one rank, optionally after a gap, and hold it until accepted
  task automatic push_rank(input logic [RANK_W-1:0] rank);
    int gap;
    if (src_stall_en && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 600) : $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 32'(rank);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every predicted element
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mostly valid ranks for the length, with boundary and out-of-range ones mixed in
  function automatic logic [RANK_W-1:0] draw_rank(input logic [LEN_W-1:0] code);
    int unsigned k;
    int unsigned lim;
    k   = (code == 0) ? 1 : (code > MAX_LEN_D) ? MAX_LEN_D : code;
    lim = pu_pkg::FAC_TABLE[k];
    case ($urandom_range(0, 9))
      0:       return RANK_W'(lim);
      1:       return RANK_W'(lim - 1);
      2:       return RANK_W'($urandom_range(lim, RANK_MAX));
      3:       return RANK_W'($urandom);
      default: return RANK_W'($urandom_range(0, lim - 1));
    endcase
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    int               p;
    int               n;
    logic [LEN_W-1:0] code;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset length of twelve: identity, reverse order, bit patterns, out-of-range
    push_rank('0);
    push_rank(RANK_W'(1));
    push_rank(RANK_W'(pu_pkg::FAC_TABLE[12] - 1));
    push_rank(RANK_W'(pu_pkg::FAC_TABLE[12]));
    push_rank(RANK_MAX);
    push_rank(RANK_W'(29'h0AAA_AAAA));
    push_rank(RANK_W'(29'h1555_5555));
    drain();

    // single-element permutation
    set_length(4'd1);
    push_rank('0);
    push_rank(RANK_W'(1));
    drain();

    // length zero behaves as one
    set_length(4'd0);
    push_rank('0);
    push_rank(RANK_MAX);
    drain();

    // code fifteen saturates at twelve
    set_length(4'd15);
    push_rank(RANK_W'(pu_pkg::FAC_TABLE[12] - 1));
    push_rank(RANK_W'(pu_pkg::FAC_TABLE[12]));
    drain();

    // length three, then a write to an empty address that must leave it alone
    set_length(4'd3);
    cfg_access(CFG_WR, SPARE_ADDR, 32'd2);
    for (n = 0; n <= 6; n++) push_rank(RANK_W'(n));
    drain();

    set_length(4'd2);
    push_rank(RANK_W'(1));
    drain();

    // random phases, one length each
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       code = 4'd12;
        1:       code = 4'd1;
        2:       code = 4'd0;
        3:       code = 4'd15;
        4:       code = 4'd2;
        default: code = LEN_W'($urandom_range(0, 15));
      endcase
      set_length(code);
      // first phase: sink holds off while the source keeps offering
      src_stall_en  = (p % 4 != 1) && (p != 0);
      sink_stall_en = (p % 4 != 1);
      if (p == 0) hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        push_rank(draw_rank(code));
        if (p == DRAIN_PHASE && n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    // let any stray item show up
    repeat (600) @(negedge clk);

    $display("%0d ranks sent (%0d out of range), %0d elements checked, %0d length settings",
             ranks_seen, rejects_seen, elems_seen, settings_used);
    $display("lengths 1..12 incl. zero and saturated codes, %0d-cycle output hold-off",
             LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: permutation_unrank_unit.f
design/pu_pkg.sv
design/pu_divider.sv
design/pu_select.sv
design/permutation_unrank_unit.sv
sim/permutation_unrank_checker.sv
sim/permutation_unrank_unit_tb.sv
